// ----- rtl/grid_astar_path_search_defines.svh -----
// Assertion macros shared by the grid path search RTL.
// Used by files that carry concurrent checks; depends on clk and arst_n in scope.
`ifndef GRID_ASTAR_PATH_SEARCH_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/gaps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the grid path search block.
// No dependencies; every other RTL file imports this package.
package gaps_pkg;

	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 32;
	localparam int CELLS     = GRID_ROWS * GRID_COLS;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int ADDR_W    = $clog2(CELLS);

	localparam int COORD_W = 6;
	localparam int COST_W  = 13;
	localparam int EST_W   = 18;
	localparam int DIR_W   = 3;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 2;

	// Heuristic operand: 256 * (dx*dx + dy*dy) for coordinates of COORD_W bits.
	localparam int SUM_W = 2 * COORD_W + 1;
	localparam int SQ_W  = SUM_W + 8;
	localparam int H_W   = (SQ_W + 1) / 2;

	localparam logic [COST_W-1:0] COST_INF    = '1;
	localparam logic [EST_W-1:0]  EST_INF     = '1;
	localparam logic [COST_W-1:0] WALK_LIMIT  = 13'd4096;

	localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

	localparam logic [1:0] REQ_WALL   = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_PATH   = 2'd2;

	localparam logic [KIND_W-1:0] RESP_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] RESP_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] RESP_PATH   = 2'd2;
	localparam logic [KIND_W-1:0] RESP_EXH    = 2'd3;

	localparam logic [IDX_W-1:0] CFG_START_X = 2'd0;
	localparam logic [IDX_W-1:0] CFG_START_Y = 2'd1;
	localparam logic [IDX_W-1:0] CFG_GOAL_X  = 2'd2;
	localparam logic [IDX_W-1:0] CFG_GOAL_Y  = 2'd3;

	localparam logic [COORD_W-1:0] RST_START_X = 6'd1;
	localparam logic [COORD_W-1:0] RST_START_Y = 6'd1;
	localparam logic [COORD_W-1:0] RST_GOAL_X  = 6'd21;
	localparam logic [COORD_W-1:0] RST_GOAL_Y  = 6'd21;

	typedef struct packed {
		logic              is_open;
		logic              is_closed;
		logic [EST_W-1:0]  est;
		logic [COST_W-1:0] cost;
		logic [DIR_W-1:0]  par;
	} node_t;

	localparam node_t NODE_CLR = '{is_open: 1'b0, is_closed: 1'b0, est: EST_INF,
		cost: COST_INF, par: DIR_NONE};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              addr_clr;
		logic              addr_inc;
		logic              clr_wr;
		logic              wall_clr;
		logic              wall_wr;
		logic              scan_rd;
		logic              best_clr;
		logic              take_best;
		logic              close_cur;
		logic              nb_first;
		logic              nb_next;
		logic              nb_rd;
		logic              nb_wr;
		logic              h_start;
		logic              h_sel_nb;
		logic              init_start;
		logic              walk_init;
		logic              walk_rd;
		logic              walk_step;
		logic              cur_rd;
		logic              path_load;
		logic              path_adv;
		logic              resp_en;
		logic              resp_path;
		logic [KIND_W-1:0] resp_kind;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic addr_last;
		logic best_found;
		logic cur_is_goal;
		logic nb_valid;
		logic k_last;
		logic h_busy;
		logic par_nz;
		logic len_full;
	} stat_t;

	function automatic logic [ROW_W-1:0] clamp_row(input logic [COORD_W-1:0] v);
		logic [COORD_W:0] wide;
		wide = {1'b0, v};
		if (wide >= (COORD_W+1)'(GRID_ROWS)) begin
			return ROW_W'(GRID_ROWS - 1);
		end
		return ROW_W'(v);
	endfunction

	function automatic logic [COL_W-1:0] clamp_col(input logic [COORD_W-1:0] v);
		logic [COORD_W:0] wide;
		wide = {1'b0, v};
		if (wide >= (COORD_W+1)'(GRID_COLS)) begin
			return COL_W'(GRID_COLS - 1);
		end
		return COL_W'(v);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] x,
		input logic [COL_W-1:0] y);
		return ADDR_W'(int'(x) * GRID_COLS + int'(y));
	endfunction

endpackage

// ----- rtl/grid_astar_path_search.sv -----
`timescale 1ns / 1ps
// Grid A* path search, top level. Depends on gaps_pkg, gaps_ctrl, gaps_dp
// and gaps_isqrt.
//
// Usage: software sets start and goal cells through the configuration write
// channel (cfg_valid/cfg_ready, always ready; write it only while busy is low)
// and then issues items on the command channel. An item is accepted at a
// clock edge with start high and busy low; req_type picks a wall write, a
// search run or a read of the next path cell. Each item yields exactly one
// response, shown for a single cycle with resp_valid high. The receiver has
// no way to stall, so it must take every response in that cycle.
// A wall write or a no-op type answers in the cycle after acceptance. A path
// read makes one or two node memory reads. A search clears the node memory
// one cell per cycle, computes the start heuristic, then per expanded cell
// scans all 1024 cells through the single node memory read port and runs the
// bit-serial square root once per neighbor; it ends with a parent walk that
// reads one node per path cell. The full-grid scan sets the rate.
// After reset the block clears the wall map and node memory with busy high
// before it accepts the first item.
module grid_astar_path_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic [gaps_pkg::COORD_W-1:0] cell_x,
	input  logic [gaps_pkg::COORD_W-1:0] cell_y,
	input  logic                         blocked,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gaps_pkg::IDX_W-1:0]   cfg_index,
	input  logic [gaps_pkg::COORD_W-1:0] cfg_data,
	output logic                         resp_valid,
	output logic [gaps_pkg::KIND_W-1:0]  resp_kind,
	output logic                         reached,
	output logic [gaps_pkg::COST_W-1:0]  path_length,
	output logic [gaps_pkg::COORD_W-1:0] out_x,
	output logic [gaps_pkg::COORD_W-1:0] out_y,
	output logic                         last_cell
);
	import gaps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Register writes never wait; the user must issue them only while the block is idle, which it does not enforce.
	assign cfg_ready = 1'b1;

	gaps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	gaps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.blocked     (blocked),
		.cmd         (cmd),
		.stat        (stat),
		.resp_valid  (resp_valid),
		.resp_kind   (resp_kind),
		.reached     (reached),
		.path_length (path_length),
		.out_x       (out_x),
		.out_y       (out_y),
		.last_cell   (last_cell)
	);

endmodule

// ----- rtl/gaps_isqrt.sv -----
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
// Depends on gaps_pkg for the operand and root widths.
module gaps_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [gaps_pkg::SQ_W-1:0] value,
	output logic                   busy,
	output logic [gaps_pkg::H_W-1:0]  root
);
	import gaps_pkg::*;

	localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (2 * ((SQ_W - 1) / 2));

	logic            busy_q;
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W:0]   trial;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q == SQ_W'(1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= BIT_INIT;
		end else if (busy_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q <= v_q - SQ_W'(trial);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[H_W-1:0];

endmodule

// ----- rtl/gaps_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the grid path search: sequences clears, scans,
// expansions and path walks. Depends on gaps_pkg and the assertion header.
`include "grid_astar_path_search_defines.svh"
module gaps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	input  gaps_pkg::stat_t  stat,
	output gaps_pkg::cmd_t   cmd,
	output logic             busy
);
	import gaps_pkg::*;

	localparam logic [4:0] S_RCLR      = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_SCLR      = 5'd2;
	localparam logic [4:0] S_INIT_H    = 5'd3;
	localparam logic [4:0] S_INIT_HW   = 5'd4;
	localparam logic [4:0] S_INIT_W    = 5'd5;
	localparam logic [4:0] S_LOOP_CHK  = 5'd6;
	localparam logic [4:0] S_SCAN_PREP = 5'd7;
	localparam logic [4:0] S_SCAN      = 5'd8;
	localparam logic [4:0] S_SCAN_END  = 5'd9;
	localparam logic [4:0] S_DECIDE    = 5'd10;
	localparam logic [4:0] S_CLOSE     = 5'd11;
	localparam logic [4:0] S_NB_SEL    = 5'd12;
	localparam logic [4:0] S_NB_W      = 5'd13;
	localparam logic [4:0] S_NB_HW     = 5'd14;
	localparam logic [4:0] S_NB_WR     = 5'd15;
	localparam logic [4:0] S_W_INIT    = 5'd16;
	localparam logic [4:0] S_W_RD      = 5'd17;
	localparam logic [4:0] S_W_W       = 5'd18;
	localparam logic [4:0] S_P_W       = 5'd19;
	localparam logic [4:0] S_P_RD2     = 5'd20;
	localparam logic [4:0] S_P_W2      = 5'd21;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       req_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RCLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_RCLR: begin
				cmd.clr_wr   = 1'b1;
				cmd.wall_clr = 1'b1;
				cmd.addr_inc = 1'b1;
				if (stat.addr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_WALL: begin
							cmd.wall_wr   = 1'b1;
							cmd.resp_en   = 1'b1;
							cmd.resp_kind = RESP_WRITE;
						end
						REQ_SEARCH: begin
							cmd.addr_clr = 1'b1;
							state_d      = S_SCLR;
						end
						REQ_PATH: begin
							cmd.cur_rd = 1'b1;
							state_d    = S_P_W;
						end
						default: begin
							cmd.resp_en   = 1'b1;
							cmd.resp_kind = RESP_WRITE;
						end
					endcase
				end
			end
			S_SCLR: begin
				cmd.clr_wr   = 1'b1;
				cmd.addr_inc = 1'b1;
				if (stat.addr_last) begin
					state_d = S_INIT_H;
				end
			end
			S_INIT_H: begin
				cmd.h_start = 1'b1;
				state_d     = S_INIT_HW;
			end
			S_INIT_HW: begin
				if (!stat.h_busy) begin
					state_d = S_INIT_W;
				end
			end
			S_INIT_W: begin
				cmd.init_start = 1'b1;
				state_d        = S_LOOP_CHK;
			end
			S_LOOP_CHK: begin
				state_d = stat.cur_is_goal ? S_W_INIT : S_SCAN_PREP;
			end
			S_SCAN_PREP: begin
				cmd.addr_clr = 1'b1;
				cmd.best_clr = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.addr_inc = 1'b1;
				if (stat.addr_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.best_found) begin
					cmd.take_best = 1'b1;
					state_d       = S_CLOSE;
				end else begin
					state_d = S_W_INIT;
				end
			end
			S_CLOSE: begin
				cmd.close_cur = 1'b1;
				cmd.nb_first  = 1'b1;
				state_d       = S_NB_SEL;
			end
			S_NB_SEL: begin
				if (stat.nb_valid) begin
					cmd.nb_rd = 1'b1;
					state_d   = S_NB_W;
				end else if (stat.k_last) begin
					state_d = S_LOOP_CHK;
				end else begin
					cmd.nb_next = 1'b1;
				end
			end
			S_NB_W: begin
				cmd.h_start  = 1'b1;
				cmd.h_sel_nb = 1'b1;
				state_d      = S_NB_HW;
			end
			S_NB_HW: begin
				if (!stat.h_busy) begin
					state_d = S_NB_WR;
				end
			end
			S_NB_WR: begin
				cmd.nb_wr = 1'b1;
				if (stat.k_last) begin
					state_d = S_LOOP_CHK;
				end else begin
					cmd.nb_next = 1'b1;
					state_d     = S_NB_SEL;
				end
			end
			S_W_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = S_W_RD;
			end
			S_W_RD: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_W_W;
			end
			S_W_W: begin
				if (stat.par_nz && !stat.len_full) begin
					cmd.walk_step = 1'b1;
					state_d       = S_W_RD;
				end else begin
					cmd.resp_en   = 1'b1;
					cmd.resp_kind = RESP_SEARCH;
					state_d       = S_IDLE;
				end
			end
			S_P_W: begin
				if (stat.par_nz) begin
					cmd.path_load = 1'b1;
					state_d       = S_P_RD2;
				end else begin
					cmd.resp_en   = 1'b1;
					cmd.resp_kind = RESP_EXH;
					state_d       = S_IDLE;
				end
			end
			S_P_RD2: begin
				cmd.walk_rd = 1'b1;
				state_d     = S_P_W2;
			end
			S_P_W2: begin
				cmd.resp_en   = 1'b1;
				cmd.resp_kind = RESP_PATH;
				cmd.resp_path = 1'b1;
				cmd.path_adv  = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// A running request returns to idle; the reset clear pass answers nothing.
	assign req_done = (state_q != S_IDLE) && (state_q != S_RCLR) && (state_d == S_IDLE);

	// Every return to idle from a running request answers that request.
	`ASSERT_CLK(a_done_has_resp, req_done |-> cmd.resp_en, "request finished without a response")
	// An expansion starts only from a cell the scan really found.
	`ASSERT_CLK(a_take_needs_best, cmd.take_best |-> stat.best_found, "expansion without an open cell")
	// A neighbor update never uses a heuristic still being computed.
	`ASSERT_NEVER(a_nb_wr_sqrt_busy, cmd.nb_wr && stat.h_busy, "neighbor written while root unit busy")

endmodule

// ----- rtl/gaps_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the grid path search: configuration registers, wall and node
// memories, scan compare, neighbor update and path walk. Depends on gaps_pkg.
module gaps_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gaps_pkg::IDX_W-1:0]  cfg_index,
	input  logic [gaps_pkg::COORD_W-1:0] cfg_data,
	input  logic [gaps_pkg::COORD_W-1:0] cell_x,
	input  logic [gaps_pkg::COORD_W-1:0] cell_y,
	input  logic                        blocked,
	input  gaps_pkg::cmd_t              cmd,
	output gaps_pkg::stat_t             stat,
	output logic                        resp_valid,
	output logic [gaps_pkg::KIND_W-1:0] resp_kind,
	output logic                        reached,
	output logic [gaps_pkg::COST_W-1:0] path_length,
	output logic [gaps_pkg::COORD_W-1:0] out_x,
	output logic [gaps_pkg::COORD_W-1:0] out_y,
	output logic                        last_cell
);
	import gaps_pkg::*;

	logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
	logic [ROW_W-1:0]   s_x, g_x;
	logic [COL_W-1:0]   s_y, g_y;

	node_t node_mem [CELLS];
	logic  wall_mem [CELLS];
	node_t node_rd_q;
	logic  wall_rd_q;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             scan_v_s1;
	logic [ROW_W-1:0] scan_x_s1;
	logic [COL_W-1:0] scan_y_s1;

	logic             best_found_q;
	logic [ROW_W-1:0] best_x_q;
	logic [COL_W-1:0] best_y_q;
	node_t            best_node_q;

	logic [ROW_W-1:0] cur_x_q;
	logic [COL_W-1:0] cur_y_q;
	node_t            cur_node_q;
	logic [DIR_W-1:0] k_q;
	logic [ROW_W-1:0] nb_x;
	logic [COL_W-1:0] nb_y;
	logic             nb_valid;

	logic [ROW_W-1:0]  n_x_q, cur_px;
	logic [COL_W-1:0]  n_y_q, cur_py;
	logic [ROW_W-1:0]  cursor_x_q;
	logic [COL_W-1:0]  cursor_y_q;
	logic [ROW_W-1:0]  par_x;
	logic [COL_W-1:0]  par_y;
	logic [COST_W-1:0] len_q;

	logic                resp_valid_q;
	logic [KIND_W-1:0]   resp_kind_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q;
	logic                last_q;

	logic               mem_we, mem_re, scan_hit;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	node_t              mem_wdata;
	logic [COST_W-1:0]  nc;

	logic [ROW_W-1:0]   h_x;
	logic [COL_W-1:0]   h_y;
	logic [COORD_W-1:0] dx, dy;
	logic [SUM_W-1:0]   sq_sum;
	logic [H_W-1:0]     h_root;
	logic               h_busy;

	assign s_x = clamp_row(sx_q);
	assign s_y = clamp_col(sy_q);
	assign g_x = clamp_row(gx_q);
	assign g_y = clamp_col(gy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= RST_START_X;
			sy_q <= RST_START_Y;
			gx_q <= RST_GOAL_X;
			gy_q <= RST_GOAL_Y;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_X: sx_q <= cfg_data;
				CFG_START_Y: sy_q <= cfg_data;
				CFG_GOAL_X:  gx_q <= cfg_data;
				CFG_GOAL_Y:  gy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Neighbor of the expanded cell for the current direction.
	always_comb begin
		nb_x     = cur_x_q;
		nb_y     = cur_y_q;
		nb_valid = 1'b0;
		case (k_q)
			DIR_UP: begin
				nb_valid = (cur_x_q != ROW_W'(GRID_ROWS - 1));
				nb_x     = cur_x_q + 1'b1;
			end
			DIR_LEFT: begin
				nb_valid = (cur_y_q != COL_W'(GRID_COLS - 1));
				nb_y     = cur_y_q + 1'b1;
			end
			DIR_RIGHT: begin
				nb_valid = (cur_y_q != '0);
				nb_y     = cur_y_q - 1'b1;
			end
			DIR_DOWN: begin
				nb_valid = (cur_x_q != '0);
				nb_x     = cur_x_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Parent step of the walked cell: from the cursor or from the walk pointer.
	always_comb begin
		cur_px = cmd.path_load ? cursor_x_q : n_x_q;
		cur_py = cmd.path_load ? cursor_y_q : n_y_q;
		par_x  = cur_px;
		par_y  = cur_py;
		case (node_rd_q.par)
			DIR_UP:    par_x = cur_px - 1'b1;
			DIR_LEFT:  par_y = cur_py - 1'b1;
			DIR_RIGHT: par_y = cur_py + 1'b1;
			DIR_DOWN:  par_x = cur_px + 1'b1;
			default: ;
		endcase
	end

	// Heuristic operand for the root unit.
	always_comb begin
		h_x    = cmd.h_sel_nb ? nb_x : s_x;
		h_y    = cmd.h_sel_nb ? nb_y : s_y;
		dx     = (h_x > g_x) ? COORD_W'(h_x - g_x) : COORD_W'(g_x - h_x);
		dy     = (h_y > g_y) ? COORD_W'(h_y - g_y) : COORD_W'(g_y - h_y);
		sq_sum = SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
	end

	gaps_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.h_start),
		.value  ({sq_sum, 8'd0}),
		.busy   (h_busy),
		.root   (h_root)
	);

	assign nc = cur_node_q.cost + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(row_q, col_q);
		mem_wdata = NODE_CLR;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
		end else if (cmd.init_start) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(s_x, s_y);
			mem_wdata = '{is_open: 1'b1, is_closed: 1'b0, est: EST_W'(h_root),
				cost: '0, par: DIR_NONE};
		end else if (cmd.close_cur) begin
			mem_we              = 1'b1;
			mem_waddr           = cell_addr(cur_x_q, cur_y_q);
			mem_wdata           = cur_node_q;
			mem_wdata.is_open   = 1'b0;
			mem_wdata.is_closed = 1'b1;
		end else if (cmd.nb_wr && !wall_rd_q && !node_rd_q.is_closed) begin
			mem_we            = 1'b1;
			mem_waddr         = cell_addr(nb_x, nb_y);
			mem_wdata         = node_rd_q;
			mem_wdata.is_open = 1'b1;
			if (nc < node_rd_q.cost) begin
				mem_wdata.cost = nc;
				mem_wdata.est  = EST_W'({nc, 4'd0}) + EST_W'(h_root);
				mem_wdata.par  = k_q;
			end
		end
	end

	always_comb begin
		mem_re    = 1'b1;
		mem_raddr = cell_addr(row_q, col_q);
		if (cmd.nb_rd) begin
			mem_raddr = cell_addr(nb_x, nb_y);
		end else if (cmd.walk_rd) begin
			mem_raddr = cell_addr(n_x_q, n_y_q);
		end else if (cmd.cur_rd) begin
			mem_raddr = cell_addr(cursor_x_q, cursor_y_q);
		end else if (!cmd.scan_rd) begin
			mem_re = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			node_rd_q <= node_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wall_clr) begin
			wall_mem[cell_addr(row_q, col_q)] <= 1'b0;
		end else if (cmd.wall_wr && ({1'b0, cell_x} < (COORD_W+1)'(GRID_ROWS))
			&& ({1'b0, cell_y} < (COORD_W+1)'(GRID_COLS))) begin
			wall_mem[cell_addr(ROW_W'(cell_x), COL_W'(cell_y))] <= blocked;
		end
		if (cmd.nb_rd) begin
			wall_rd_q <= wall_mem[cell_addr(nb_x, nb_y)];
		end
	end

	// Lowest estimate wins; a strict compare keeps the lowest row-major index on ties.
	assign scan_hit = scan_v_s1 && node_rd_q.is_open && !node_rd_q.is_closed
		&& (!best_found_q || node_rd_q.est < best_node_q.est);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			col_q        <= '0;
			scan_v_s1    <= 1'b0;
			best_found_q <= 1'b0;
			len_q        <= '0;
			cursor_x_q   <= clamp_row(RST_GOAL_X);
			cursor_y_q   <= clamp_col(RST_GOAL_Y);
			resp_valid_q <= 1'b0;
		end else begin
			scan_v_s1    <= cmd.scan_rd;
			resp_valid_q <= cmd.resp_en;
			if (cmd.addr_clr) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cmd.addr_inc) begin
				if (col_q == COL_W'(GRID_COLS - 1)) begin
					col_q <= '0;
					row_q <= (row_q == ROW_W'(GRID_ROWS - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.best_clr) begin
				best_found_q <= 1'b0;
			end else if (scan_hit) begin
				best_found_q <= 1'b1;
			end
			if (cmd.walk_init) begin
				len_q      <= '0;
				cursor_x_q <= g_x;
				cursor_y_q <= g_y;
			end else if (cmd.walk_step) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.path_adv) begin
				cursor_x_q <= n_x_q;
				cursor_y_q <= n_y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_x_s1 <= row_q;
		scan_y_s1 <= col_q;
		if (scan_hit) begin
			best_x_q    <= scan_x_s1;
			best_y_q    <= scan_y_s1;
			best_node_q <= node_rd_q;
		end
		if (cmd.init_start) begin
			cur_x_q <= s_x;
			cur_y_q <= s_y;
		end else if (cmd.take_best) begin
			cur_x_q    <= best_x_q;
			cur_y_q    <= best_y_q;
			cur_node_q <= best_node_q;
		end
		if (cmd.nb_first) begin
			k_q <= DIR_UP;
		end else if (cmd.nb_next) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.walk_init) begin
			n_x_q <= g_x;
			n_y_q <= g_y;
		end else if (cmd.walk_step || cmd.path_load) begin
			n_x_q <= par_x;
			n_y_q <= par_y;
		end
		resp_kind_q <= cmd.resp_kind;
		if (cmd.resp_path) begin
			out_x_q <= COORD_W'(cursor_x_q);
			out_y_q <= COORD_W'(cursor_y_q);
			last_q  <= (node_rd_q.par == DIR_NONE);
		end else begin
			out_x_q <= '0;
			out_y_q <= '0;
			last_q  <= 1'b0;
		end
	end

	assign stat.addr_last   = (row_q == ROW_W'(GRID_ROWS - 1)) && (col_q == COL_W'(GRID_COLS - 1));
	assign stat.best_found  = best_found_q;
	assign stat.cur_is_goal = (cur_x_q == g_x) && (cur_y_q == g_y);
	assign stat.nb_valid    = nb_valid;
	assign stat.k_last      = (k_q == DIR_DOWN);
	assign stat.h_busy      = h_busy;
	assign stat.par_nz      = (node_rd_q.par != DIR_NONE);
	assign stat.len_full    = (len_q == WALK_LIMIT);

	assign resp_valid  = resp_valid_q;
	assign resp_kind   = resp_kind_q;
	assign reached     = (len_q != '0);
	assign path_length = len_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign last_cell   = last_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for grid_astar_path_search: wall writes, searches and path reads
// are checked against an in-bench A* predictor. Depends on gaps_pkg and the RTL top level.
module tb;
	import gaps_pkg::*;

	// Request type 3 has no package name; the block treats it as a no-op.
	localparam logic [1:0] REQ_NOP = 2'd3;
	// The limit leaves room for every search of the run to flood the whole grid
	// several times over.
	localparam int RUN_LIMIT = 50000000;

	typedef struct {
		logic [1:0]         req;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               blk;
	} req_item_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic               reached;
		logic [COST_W-1:0]  len;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} resp_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = '0;
	logic [COORD_W-1:0] cell_x = '0;
	logic [COORD_W-1:0] cell_y = '0;
	logic blocked = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic resp_valid;
	logic [KIND_W-1:0] resp_kind;
	logic reached;
	logic [COST_W-1:0] path_length;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic last_cell;

	grid_astar_path_search dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cell_x(cell_x), .cell_y(cell_y), .blocked(blocked),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .resp_valid(resp_valid), .resp_kind(resp_kind),
		.reached(reached), .path_length(path_length), .out_x(out_x), .out_y(out_y),
		.last_cell(last_cell)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow state of the block: wall map, per-search node stores, registers and path walk.
	bit               walls [CELLS];
	logic [COST_W-1:0] g_cost [CELLS];
	logic [EST_W-1:0]  f_est [CELLS];
	bit               is_open [CELLS];
	bit               is_closed [CELLS];
	logic [DIR_W-1:0]  came_from [CELLS];
	logic [COORD_W-1:0] reg_sx = RST_START_X, reg_sy = RST_START_Y;
	logic [COORD_W-1:0] reg_gx = RST_GOAL_X, reg_gy = RST_GOAL_Y;
	int cursor = 21 * GRID_COLS + 21;
	bit last_reached = 0;
	int last_len = 0;
	int step_dx [5] = '{0, -1, 0, 0, 1};
	int step_dy [5] = '{0, 0, -1, 1, 0};

	req_item_t  cmd_q [$];
	resp_item_t want_q [$];
	int fails = 0;

	function automatic int lim_row(logic [COORD_W-1:0] v);
		return (v >= GRID_ROWS) ? GRID_ROWS - 1 : int'(v);
	endfunction

	function automatic int lim_col(logic [COORD_W-1:0] v);
		return (v >= GRID_COLS) ? GRID_COLS - 1 : int'(v);
	endfunction

	// Truncated 16 * Euclidean distance, i.e. floor(sqrt(256 * (dx^2 + dy^2))).
	function automatic int dist16(int x, int y, int gx, int gy);
		int dx, dy, v, r;
		dx = (x > gx) ? x - gx : gx - x;
		dy = (y > gy) ? y - gy : gy - y;
		v = 256 * (dx * dx + dy * dy);
		r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	// Returns the parent cell index of idx, or -1 when it has no parent.
	function automatic int parent_cell(int idx);
		int d, x, y;
		d = came_from[idx];
		if (d == 0 || d > 4) return -1;
		x = idx / GRID_COLS + step_dx[d];
		y = idx % GRID_COLS + step_dy[d];
		if (x < 0 || y < 0 || x >= GRID_ROWS || y >= GRID_COLS) return -1;
		return x * GRID_COLS + y;
	endfunction

	task automatic astar_search();
		int sx, sy, gx, gy, s, g, cur, best, k, nx, ny, ni, nc, n;
		logic [EST_W:0] bestf;
		sx = lim_row(reg_sx); sy = lim_col(reg_sy);
		gx = lim_row(reg_gx); gy = lim_col(reg_gy);
		s = sx * GRID_COLS + sy;
		g = gx * GRID_COLS + gy;
		for (int i = 0; i < CELLS; i++) begin
			g_cost[i] = COST_INF; f_est[i] = EST_INF;
			is_open[i] = 0; is_closed[i] = 0; came_from[i] = DIR_NONE;
		end
		g_cost[s] = 0;
		f_est[s] = dist16(sx, sy, gx, gy);
		is_open[s] = 1;
		cur = s;
		while (cur != g) begin
			best = -1;
			bestf = {1'b0, EST_INF} + 1;
			// Strict compare keeps the lowest index on equal estimates.
			for (int i = 0; i < CELLS; i++) begin
				if (is_open[i] && !is_closed[i] && f_est[i] < bestf) begin
					bestf = f_est[i];
					best = i;
				end
			end
			if (best < 0) break;
			cur = best;
			is_closed[cur] = 1;
			is_open[cur] = 0;
			for (k = 1; k <= 4; k++) begin
				nx = cur / GRID_COLS - step_dx[k];
				ny = cur % GRID_COLS - step_dy[k];
				if (nx < 0 || ny < 0 || nx >= GRID_ROWS || ny >= GRID_COLS) continue;
				ni = nx * GRID_COLS + ny;
				if (walls[ni] || is_closed[ni]) continue;
				is_open[ni] = 1;
				nc = g_cost[cur] + 1;
				if (nc < g_cost[ni]) begin
					g_cost[ni] = nc;
					f_est[ni] = 16 * nc + dist16(nx, ny, gx, gy);
					came_from[ni] = k;
				end
			end
		end
		last_reached = (came_from[g] != DIR_NONE);
		last_len = 0;
		n = g;
		while (last_len < 4096 && parent_cell(n) >= 0) begin
			last_len++;
			n = parent_cell(n);
		end
		cursor = g;
	endtask

	task automatic predict_response(input req_item_t it, output resp_item_t r);
		int p;
		r.kind = RESP_WRITE; r.x = '0; r.y = '0; r.last = 1'b0;
		case (it.req)
			REQ_WALL: begin
				if (it.x < GRID_ROWS && it.y < GRID_COLS)
					walls[int'(it.x) * GRID_COLS + int'(it.y)] = it.blk;
			end
			REQ_SEARCH: begin
				astar_search();
				r.kind = RESP_SEARCH;
			end
			REQ_PATH: begin
				p = parent_cell(cursor);
				if (p >= 0) begin
					r.kind = RESP_PATH;
					r.x = cursor / GRID_COLS;
					r.y = cursor % GRID_COLS;
					r.last = (parent_cell(p) < 0);
					cursor = p;
				end else begin
					r.kind = RESP_EXH;
				end
			end
			default: begin
			end
		endcase
		r.reached = last_reached;
		r.len = last_len;
	endtask

	// Driver: bursts of items separated by random gaps, one start assignment per edge.
	req_item_t drv;
	bit have = 0;
	int gap = 0;
	int burst = 1;

	always @(posedge clk) begin
		resp_item_t r;
		if (arst_n) begin
			if (start && !busy) begin
				predict_response(drv, r);
				want_q = {want_q, r};
				have = 0;
				burst--;
				if (burst <= 0) begin
					burst = $urandom_range(1, 8);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (gap > 0) begin
				gap--;
			end else if (!have && cmd_q.size() > 0) begin
				drv = cmd_q[0];
				cmd_q.delete(0);
				have = 1;
			end
			start <= have;
			req_type <= drv.req;
			cell_x <= drv.x;
			cell_y <= drv.y;
			blocked <= drv.blk;
		end
	end

	// Monitor: every strobed response must match the oldest prediction.
	always @(posedge clk) begin
		resp_item_t w;
		if (arst_n && resp_valid) begin
			if (want_q.size() == 0) begin
				$display("%0t: unexpected response kind %0d", $time, resp_kind);
				fails++;
			end else begin
				w = want_q[0];
				want_q.delete(0);
				if (resp_kind !== w.kind) begin
					$display("%0t: resp_kind exp %0d got %0d", $time, w.kind, resp_kind);
					fails++;
				end
				if (reached !== w.reached) begin
					$display("%0t: reached exp %0d got %0d", $time, w.reached, reached);
					fails++;
				end
				if (path_length !== w.len) begin
					$display("%0t: path_length exp %0d got %0d", $time, w.len, path_length);
					fails++;
				end
				if (out_x !== w.x || out_y !== w.y) begin
					$display("%0t: cell exp (%0d,%0d) got (%0d,%0d)", $time, w.x, w.y,
						out_x, out_y);
					fails++;
				end
				if (last_cell !== w.last) begin
					$display("%0t: last_cell exp %0d got %0d", $time, w.last, last_cell);
					fails++;
				end
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("grid_astar_path_search test failed");
			$finish;
		end
	end

	task automatic add(logic [1:0] req, int x, int y, bit blk);
		req_item_t it;
		it.req = req; it.x = x; it.y = y; it.blk = blk;
		cmd_q = {cmd_q, it};
	endtask

	// Waits until every item is answered and the block is idle.
	task automatic drain();
		do @(posedge clk); while (cmd_q.size() != 0 || have || start || busy
			|| want_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Writes all four registers back to back; valid stays high across them.
	task automatic set_cells(int sx, int sy, int gx, int gy);
		int vals [4];
		logic [IDX_W-1:0] idx [4];
		vals = '{sx, sy, gx, gy};
		idx = '{CFG_START_X, CFG_START_Y, CFG_GOAL_X, CFG_GOAL_Y};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_START_X: reg_sx = vals[i];
				CFG_START_Y: reg_sy = vals[i];
				CFG_GOAL_X:  reg_gx = vals[i];
				default:     reg_gy = vals[i];
			endcase
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int sx, sy, gx, gy, n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A path read before any search is exhausted; type 3 is a no-op.
		add(REQ_PATH, 0, 0, 0);
		add(REQ_NOP, 63, 63, 1);
		// Writes outside the grid leave the map alone.
		add(REQ_WALL, 40, 5, 1);
		add(REQ_WALL, 63, 63, 1);
		// Wall in the start corner so that unreachable searches stay cheap.
		add(REQ_WALL, 0, 1, 1);
		add(REQ_WALL, 1, 0, 1);
		add(REQ_WALL, 5, 5, 1);
		drain();

		// Unreachable goal, clamped to the far corner.
		set_cells(0, 0, 63, 63);
		add(REQ_SEARCH, 0, 0, 0);
		add(REQ_PATH, 0, 0, 0);
		drain();

		// Goal is a wall; then start equals goal.
		set_cells(0, 0, 5, 5);
		add(REQ_SEARCH, 0, 0, 0);
		drain();
		set_cells(0, 0, 0, 0);
		add(REQ_SEARCH, 0, 0, 0);
		add(REQ_PATH, 0, 0, 0);
		drain();

		// Start is a wall but its neighbors are open.
		add(REQ_WALL, 3, 3, 1);
		drain();
		set_cells(3, 3, 3, 6);
		add(REQ_SEARCH, 0, 0, 0);
		for (int i = 0; i < 5; i++) add(REQ_PATH, 0, 0, 0);
		drain();

		// Register extremes: the start is clamped to the last row and column, the goal to the last row.
		set_cells(63, 63, 63, 29);
		add(REQ_SEARCH, 0, 0, 0);
		// Changing a wall after a search keeps the stored path.
		add(REQ_WALL, 31, 30, 1);
		for (int i = 0; i < 4; i++) add(REQ_PATH, 0, 0, 0);
		drain();

		// Random part: short searches among random walls near the start.
		for (int ph = 0; ph < 8; ph++) begin
			sx = $urandom_range(0, 63);
			sy = $urandom_range(0, 63);
			gx = lim_row(sx) + $urandom_range(0, 6) - 3;
			gy = lim_col(sy) + $urandom_range(0, 6) - 3;
			gx = (gx < 0) ? 0 : (gx > 31 ? 31 : gx);
			gy = (gy < 0) ? 0 : (gy > 31 ? 31 : gy);
			if (gx == 31 && $urandom_range(0, 1)) gx = $urandom_range(31, 63);
			if (gy == 31 && $urandom_range(0, 1)) gy = $urandom_range(31, 63);
			set_cells(sx, sy, gx, gy);
			n = $urandom_range(5, 8);
			for (int i = 0; i < n; i++) begin
				int wx, wy;
				bit b;
				if ($urandom_range(0, 3) == 0) begin
					wx = $urandom_range(0, 63);
					wy = $urandom_range(0, 63);
				end else begin
					wx = lim_row(sx) + $urandom_range(0, 6) - 3;
					wy = lim_col(sy) + $urandom_range(0, 6) - 3;
					wx = (wx < 0) ? 0 : (wx > 31 ? 31 : wx);
					wy = (wy < 0) ? 0 : (wy > 31 ? 31 : wy);
				end
				b = ($urandom_range(0, 2) == 0);
				// A walled goal with an open start would flood the whole grid.
				if (wx == lim_row(gx) && wy == lim_col(gy)) b = 0;
				add(REQ_WALL, wx, wy, b);
			end
			if ($urandom_range(0, 2) == 0) add(REQ_NOP, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 1));
			add(REQ_WALL, lim_row(gx), lim_col(gy), 0);
			add(REQ_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 1));
			n = $urandom_range(4, 9);
			for (int i = 0; i < n; i++)
				add(REQ_PATH, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1));
			drain();
		end

		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("grid_astar_path_search test passed");
		end else begin
			$display("grid_astar_path_search test failed");
		end
		$finish;
	end
endmodule
